FILE: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands used by the free list top level.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check the consequent in the same cycle as the antecedent.
`define PPBFL_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("free list assertion failed");

// Check the consequent in the cycle after the antecedent.
`define PPBFL_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("free list assertion failed");

`endif

FILE: sv/ppbfl_pkg.sv
// ----------------------------------------------------------------------------
// ppbfl_pkg
// Types and constants of the per-port buffer free list.
// ----------------------------------------------------------------------------
package ppbfl_pkg;

   // Geometry
   localparam int PORT_COUNT  = 2;
   localparam int PORT_BITS   = 1;
   localparam int STACK_DEPTH = 1024;
   localparam int DEPTH_BITS  = $clog2(STACK_DEPTH);
   localparam int LEVEL_BITS  = DEPTH_BITS + 1;
   localparam int ADDR_BITS   = PORT_BITS + DEPTH_BITS;
   localparam int STORE_DEPTH = PORT_COUNT * STACK_DEPTH;
   localparam int HANDLE_BITS = 32;

   // Request operation codes
   localparam logic FUNC_ALLOC = 1'b0;
   localparam logic FUNC_FREE  = 1'b1;

   // Result status codes
   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_EMPTY = 2'd1,
      STATUS_FULL  = 2'd2
   } status_type;

   // Controller states
   typedef enum logic {
      ST_IDLE,
      ST_LOAD
   } state_type;

   // Commands from controller to datapath
   typedef struct packed {
      logic accept;   // request transfer this cycle
      logic load;     // load the result register
   } cmd_type;

endpackage

FILE: sv/ppbfl_if.sv
// ----------------------------------------------------------------------------
// ppbfl_req_if / ppbfl_rsp_if
// Valid/ready channels carrying free list requests and results.
// ----------------------------------------------------------------------------
interface ppbfl_req_if import ppbfl_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic                   func;
   logic [PORT_BITS-1:0]   port;
   logic [HANDLE_BITS-1:0] buffer_handle;

   modport source (output valid, func, port, buffer_handle, input ready);
   modport sink   (input valid, func, port, buffer_handle, output ready);
endinterface

interface ppbfl_rsp_if import ppbfl_pkg::*; ();
   logic                   valid;
   logic                   ready;
   status_type             status;
   logic [HANDLE_BITS-1:0] granted_handle;
   logic [LEVEL_BITS-1:0]  fill_count;

   modport source (output valid, status, granted_handle, fill_count, input ready);
   modport sink   (input valid, status, granted_handle, fill_count, output ready);
endinterface

FILE: sv/ppbfl_ctrl.sv
// ----------------------------------------------------------------------------
// ppbfl_ctrl
// Request sequencer: takes one request, waits for the store read, then loads
// the result register once it is free or draining.
// ----------------------------------------------------------------------------
module ppbfl_ctrl import ppbfl_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output cmd_type cmd
);

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   // State and result valid registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Next state and commands
   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      cmd          = '0;
      req_ready    = 1'b0;
      // drop the result once it transfers
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = ST_LOAD;
            end
         end
         ST_LOAD: begin
            // hold until the result register is free or draining
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.load     = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

FILE: sv/ppbfl_dp.sv
// ----------------------------------------------------------------------------
// ppbfl_dp
// Fill levels, handle store and result register of the free list.
// ----------------------------------------------------------------------------
module ppbfl_dp import ppbfl_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  cmd_type                cmd,
   input  logic                   func,
   input  logic [PORT_BITS-1:0]   port,
   input  logic [HANDLE_BITS-1:0] buffer_handle,
   output status_type             status,
   output logic [HANDLE_BITS-1:0] granted_handle,
   output logic [LEVEL_BITS-1:0]  fill_count
);

   logic [LEVEL_BITS-1:0]  level_ff [PORT_COUNT];
   logic [HANDLE_BITS-1:0] store [STORE_DEPTH];
   logic [HANDLE_BITS-1:0] rd_data_ff;

   // Values captured at the request transfer
   status_type             pend_status_ff, pend_status_in;
   logic                   pend_grant_ff;
   logic [LEVEL_BITS-1:0]  pend_level_ff, pend_level_in;

   status_type             rsp_status_ff;
   logic [HANDLE_BITS-1:0] rsp_handle_ff;
   logic [LEVEL_BITS-1:0]  rsp_level_ff;

   logic [LEVEL_BITS-1:0]  level;
   logic [LEVEL_BITS-1:0]  level_dec;
   logic                   is_full, is_empty;
   logic                   push_en, pop_en;
   logic [DEPTH_BITS-1:0]  slot;
   logic [ADDR_BITS-1:0]   addr;

   // Decode the request against the port's fill level
   always_comb begin
      level     = level_ff[port];
      level_dec = level - LEVEL_BITS'(1);
      is_full   = (level == LEVEL_BITS'(STACK_DEPTH));
      is_empty  = (level == '0);
      push_en   = cmd.accept && (func == FUNC_FREE) && !is_full;
      pop_en    = cmd.accept && (func == FUNC_ALLOC) && !is_empty;
      slot      = (func == FUNC_FREE) ? level[DEPTH_BITS-1:0] : level_dec[DEPTH_BITS-1:0];
      addr      = {port, slot};

      pend_status_in = STATUS_OK;
      pend_level_in  = level;
      priority if (func == FUNC_FREE) begin
         if (is_full) begin
            pend_status_in = STATUS_FULL;
         end else begin
            pend_level_in = level + LEVEL_BITS'(1);
         end
      end else begin
         if (is_empty) begin
            pend_status_in = STATUS_EMPTY;
         end else begin
            pend_level_in = level_dec;
         end
      end
   end

   // Update fill levels
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < PORT_COUNT; i++) begin
            level_ff[i] <= '0;
         end
      end else if (cmd.accept) begin
         level_ff[port] <= pend_level_in;
      end
   end

   // Handle store: push writes, pop reads into a register
   always_ff @(posedge clock) begin
      if (push_en) begin
         store[addr] <= buffer_handle;
      end
      if (pop_en) begin
         rd_data_ff <= store[addr];
      end
   end

   // Hold the request outcome while the store read completes
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         pend_status_ff <= pend_status_in;
         pend_grant_ff  <= pop_en;
         pend_level_ff  <= pend_level_in;
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         rsp_status_ff <= pend_status_ff;
         rsp_handle_ff <= pend_grant_ff ? rd_data_ff : '0;
         rsp_level_ff  <= pend_level_ff;
      end
   end

   assign status         = rsp_status_ff;
   assign granted_handle = rsp_handle_ff;
   assign fill_count     = rsp_level_ff;

endmodule

FILE: sv/per_port_buffer_free_list.sv
// ----------------------------------------------------------------------------
// per_port_buffer_free_list
// One last-in-first-out stack of free buffer handles for each port.
// ----------------------------------------------------------------------------
// Usage:
//   req_chan carries func (0 allocate, 1 free), port and buffer_handle.
//   rsp_chan returns one result per request: status (ok, empty, full),
//   granted_handle (zero unless an allocate succeeds) and the port's fill
//   count after the request.
//   The result is loaded once the handle store's registered read has returned
//   and the result register is free or draining.
//   One request is in flight at a time; the handle store is single-ported with
//   a registered read, and the sequencer takes the next request after the
//   result register is loaded.
//   A result waiting on a stalled receiver does not block the next request;
//   the one after that waits until the held result transfers.
//   Reset empties every stack at once (no clearing pass); software fills the
//   stacks with free requests. Store entries are valid only once pushed.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module per_port_buffer_free_list import ppbfl_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   ppbfl_req_if.sink   req_chan,
   ppbfl_rsp_if.source rsp_chan
);

   cmd_type cmd;

   // Sequencer
   ppbfl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .cmd       (cmd)
   );

   // Stacks and result register
   ppbfl_dp u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .func           (req_chan.func),
      .port           (req_chan.port),
      .buffer_handle  (req_chan.buffer_handle),
      .status         (rsp_chan.status),
      .granted_handle (rsp_chan.granted_handle),
      .fill_count     (rsp_chan.fill_count)
   );

   // Checks
   `PPBFL_ASSERT_NEXT(a_one_in_flight, req_chan.valid && req_chan.ready, !req_chan.ready)
   `PPBFL_ASSERT_SAME(a_fail_zero_handle, rsp_chan.valid && rsp_chan.status != STATUS_OK, rsp_chan.granted_handle == '0)
   `PPBFL_ASSERT_SAME(a_full_level, rsp_chan.valid && rsp_chan.status == STATUS_FULL, rsp_chan.fill_count == LEVEL_BITS'(STACK_DEPTH))
   `PPBFL_ASSERT_SAME(a_empty_level, rsp_chan.valid && rsp_chan.status == STATUS_EMPTY, rsp_chan.fill_count == '0)

endmodule

FILE: test/ppbfl_tb_pkg.sv
// ----------------------------------------------------------------------------
// ppbfl_tb_pkg
// Scoreboard for the per-port buffer free list: keeps a shadow copy of every
// port's handle stack, predicts the result of each request transfer and
// checks the results that come back, in order, field by field.
// ----------------------------------------------------------------------------
package ppbfl_tb_pkg;
   import ppbfl_pkg::*;

   // One predicted result
   typedef struct packed {
      status_type             status;
      logic [HANDLE_BITS-1:0] granted_handle;
      logic [LEVEL_BITS-1:0]  fill_count;
   } free_list_result_type;

   class free_list_scoreboard;
      logic [LEVEL_BITS-1:0]  shadow_level [PORT_COUNT];
      logic [HANDLE_BITS-1:0] shadow_stack [PORT_COUNT][STACK_DEPTH];
      free_list_result_type   pending_results [$];
      int                     error_count;

      function new();
         foreach (shadow_level[p]) shadow_level[p] = '0;
         error_count = 0;
      endfunction

      // Print one mismatch line and count it
      task report(input string msg);
         error_count++;
         $display("ERROR %0t: %s", $realtime, msg);
      endtask

      // Apply one accepted request to the shadow stacks and queue its result
      function void note_request(input logic func, input logic [PORT_BITS-1:0] port,
                                 input logic [HANDLE_BITS-1:0] handle);
         free_list_result_type predicted;
         int unsigned          level;
         level = shadow_level[port];
         predicted.status = STATUS_OK;
         predicted.granted_handle = '0;
         if (func == FUNC_FREE) begin
            // push, or refuse when the stack is at its depth
            if (level >= STACK_DEPTH) begin
               predicted.status = STATUS_FULL;
            end else begin
               shadow_stack[port][level] = handle;
               level++;
            end
         end else begin
            // pop the newest handle, or report empty
            if (level == 0) begin
               predicted.status = STATUS_EMPTY;
            end else begin
               level--;
               predicted.granted_handle = shadow_stack[port][level];
            end
         end
         shadow_level[port] = level[LEVEL_BITS-1:0];
         predicted.fill_count = level[LEVEL_BITS-1:0];
         pending_results.push_back(predicted);
      endfunction

      // Compare one result transfer against the oldest prediction
      task check_result(input status_type status, input logic [HANDLE_BITS-1:0] handle,
                        input logic [LEVEL_BITS-1:0] fill);
         free_list_result_type want;
         if (pending_results.size() == 0) begin
            report($sformatf("unexpected result: status %0d handle %h fill %0d",
                             status, handle, fill));
            return;
         end
         want = pending_results.pop_front();
         if (status !== want.status)
            report($sformatf("status %0d, expected %0d", status, want.status));
         if (handle !== want.granted_handle)
            report($sformatf("granted_handle %h, expected %h", handle,
                             want.granted_handle));
         if (fill !== want.fill_count)
            report($sformatf("fill_count %0d, expected %0d", fill, want.fill_count));
      endtask

      // Flag predictions that never got a result
      task check_leftovers();
         if (pending_results.size() != 0)
            report($sformatf("%0d results never arrived", pending_results.size()));
      endtask
   endclass

endpackage

FILE: test/tb_per_port_buffer_free_list.sv
// ----------------------------------------------------------------------------
// tb_per_port_buffer_free_list
// Drives allocate and free requests into the free list with random gaps on
// both channels, none in the last third: a directed opening, one port filled
// to full and pushed past it, then random bursts that grow, drain and mix on
// both ports. Results are checked against the scoreboard's shadow stacks.
// ----------------------------------------------------------------------------
module tb_per_port_buffer_free_list;
   timeunit 1ns;
   timeprecision 1ps;

   import ppbfl_pkg::*;
   import ppbfl_tb_pkg::*;

   typedef struct packed {
      logic                   func;
      logic [PORT_BITS-1:0]   port;
      logic [HANDLE_BITS-1:0] handle;
   } request_type;

   typedef enum int {
      BURST_DRAIN,
      BURST_GROW,
      BURST_MIXED
   } burst_kind_type;

   localparam int TOTAL_REQUESTS = 1570;

   logic clock;
   logic reset;

   ppbfl_req_if req_bus ();
   ppbfl_rsp_if rsp_bus ();

   per_port_buffer_free_list DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   free_list_scoreboard free_list_sb = new();

   request_type requests [$];
   int          build_level [PORT_COUNT];
   int unsigned send_idle_pct;
   int unsigned recv_idle_pct;

   // Clock and reset
   initial clock = 1'b0;
   always #5 clock = ~clock;

   initial begin
      reset = 1'b1;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
   end

   // Stall the result channel at random
   always @(posedge clock) begin
      if (reset)
         rsp_bus.ready <= 1'b0;
      else
         rsp_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // Note request transfers and check result transfers
   always @(posedge clock) begin
      if (!reset) begin
         if (req_bus.valid && req_bus.ready)
            free_list_sb.note_request(req_bus.func, req_bus.port, req_bus.buffer_handle);
         if (rsp_bus.valid && rsp_bus.ready)
            free_list_sb.check_result(rsp_bus.status, rsp_bus.granted_handle,
                                      rsp_bus.fill_count);
      end
   end

   // Handle values with extra weight on the extremes
   function automatic logic [HANDLE_BITS-1:0] pick_handle();
      case ($urandom_range(7))
         0: pick_handle = '0;
         1: pick_handle = '1;
         default: pick_handle = $urandom;
      endcase
   endfunction

   // Append a request and track the fill level it leads to
   function automatic void add_request(input logic func, input int port,
                                       input logic [HANDLE_BITS-1:0] handle);
      request_type item;
      item.func   = func;
      item.port   = port[PORT_BITS-1:0];
      item.handle = handle;
      requests.push_back(item);
      if (func == FUNC_FREE && build_level[port] < STACK_DEPTH)
         build_level[port]++;
      else if (func == FUNC_ALLOC && build_level[port] > 0)
         build_level[port]--;
   endfunction

   task automatic build_requests();
      int             full_port;
      int             burst_port;
      int             burst_len;
      int unsigned    free_pct;
      burst_kind_type burst_kind;
      foreach (build_level[p]) build_level[p] = 0;

      // Directed: empty pops, extreme handles, exact LIFO order
      add_request(FUNC_ALLOC, 0, 32'h0000_0000);
      add_request(FUNC_ALLOC, 1, 32'hFFFF_FFFF);
      add_request(FUNC_FREE,  0, 32'h0000_0000);
      add_request(FUNC_FREE,  0, 32'hFFFF_FFFF);
      add_request(FUNC_FREE,  1, 32'h5A5A_5A5A);
      add_request(FUNC_FREE,  1, 32'hA5A5_A5A5);
      add_request(FUNC_FREE,  0, 32'h0000_0001);
      add_request(FUNC_FREE,  0, 32'h8000_0000);
      add_request(FUNC_ALLOC, 0, 32'hFFFF_FFFF);
      add_request(FUNC_ALLOC, 0, 32'h0000_0000);
      add_request(FUNC_ALLOC, 0, 32'h1234_5678);
      add_request(FUNC_ALLOC, 0, 32'h0000_0000);
      add_request(FUNC_ALLOC, 0, 32'h0000_0000);
      add_request(FUNC_ALLOC, 1, 32'h0000_0000);
      add_request(FUNC_ALLOC, 1, 32'h0000_0000);
      add_request(FUNC_ALLOC, 1, 32'h0000_0000);
      add_request(FUNC_FREE,  1, 32'hFFFF_FFFF);
      add_request(FUNC_ALLOC, 1, 32'h0000_0000);

      // Fill one port to its depth with light traffic on the other
      full_port = $urandom_range(PORT_COUNT - 1);
      while (build_level[full_port] < STACK_DEPTH) begin
         if ($urandom_range(99) < 10)
            add_request($urandom_range(1) ? FUNC_FREE : FUNC_ALLOC, 1 - full_port,
                        pick_handle());
         else
            add_request(($urandom_range(99) < 95) ? FUNC_FREE : FUNC_ALLOC, full_port,
                        pick_handle());
      end
      // Push past full
      repeat (4) add_request(FUNC_FREE, full_port, pick_handle());

      // Random bursts that drain, grow or mix
      while (requests.size() < TOTAL_REQUESTS) begin
         burst_port = $urandom_range(PORT_COUNT - 1);
         burst_kind = burst_kind_type'($urandom_range(2));
         burst_len  = $urandom_range(1, 40);
         case (burst_kind)
            BURST_DRAIN: free_pct = 10;
            BURST_GROW:  free_pct = 75;
            default:     free_pct = 50;
         endcase
         repeat (burst_len)
            add_request(($urandom_range(99) < free_pct) ? FUNC_FREE : FUNC_ALLOC,
                        burst_port, pick_handle());
      end
   endtask

   // Present one request, with random idle cycles before it
   task automatic drive_request(input request_type item);
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid         <= 1'b1;
      req_bus.func          <= item.func;
      req_bus.port          <= item.port;
      req_bus.buffer_handle <= item.handle;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
   endtask

   // Hold the sender until every predicted result has been seen
   task automatic wait_for_results();
      req_bus.valid <= 1'b0;
      // let the monitor note the last transfer first
      @(posedge clock);
      while (free_list_sb.pending_results.size() != 0) @(posedge clock);
   endtask

   // Main sequence
   initial begin
      int phase_len;
      req_bus.valid         = 1'b0;
      req_bus.func          = FUNC_ALLOC;
      req_bus.port          = '0;
      req_bus.buffer_handle = '0;
      send_idle_pct         = 17;
      recv_idle_pct         = 81;

      build_requests();
      phase_len = requests.size() / 3;
      @(negedge reset);
      @(posedge clock);

      foreach (requests[i]) begin
         if (i == phase_len) begin
            wait_for_results();
            send_idle_pct = 81;
            recv_idle_pct = 17;
         end else if (i == 2 * phase_len) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         drive_request(requests[i]);
      end

      // Drain, then allow the pipeline to settle
      wait_for_results();
      repeat (10) @(posedge clock);
      free_list_sb.check_leftovers();
      if (free_list_sb.error_count == 0)
         $display("PASS per_port_buffer_free_list");
      else
         $display("FAIL per_port_buffer_free_list");
      $finish;
   end

   // Timeout
   initial begin
      #5_000_000;
      $display("FAIL per_port_buffer_free_list");
      $finish;
   end

endmodule
